/* src/vzd_pkg.sv */
// shared constants and types for the varint zigzag decoder
package vzd_pkg;

  localparam int unsigned DefaultValueWidth = 32;
  localparam int unsigned PayloadBits       = 7;
  localparam int unsigned QueueDepth        = 2;

  // control bits that travel with each byte from front to back
  typedef struct packed {
    logic last;    // top bit clear, number ends here
    logic excess;  // byte beyond the position limit, payload ignored
  } vzd_tag_t;

endpackage

/* src/vzd_front.sv */
// front end: accepts stream bytes and tags them with position and end-of-number
module vzd_front #(
  parameter int unsigned MaxBytes = 5
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [7:0]                      in_byte_i,
  input  logic                            full_i,
  output logic                            push_o,
  output logic [$clog2(MaxBytes)-1:0]     pos_o,
  output logic [vzd_pkg::PayloadBits-1:0] payload_o,
  output vzd_pkg::vzd_tag_t               tag_o
);

  localparam int unsigned PosW = $clog2(MaxBytes);
  localparam int unsigned IdxW = $clog2(MaxBytes + 1);

  logic [IdxW-1:0] idx_q, idx_d;
  logic            accept;

  assign in_ready_o = ~full_i;
  assign accept     = in_valid_i & ~full_i;
  assign push_o     = accept;

  assign payload_o  = in_byte_i[vzd_pkg::PayloadBits-1:0];
  assign pos_o      = idx_q[PosW-1:0];
  assign tag_o.last   = ~in_byte_i[7];
  assign tag_o.excess = (idx_q == IdxW'(MaxBytes));

  always_comb begin
    idx_d = idx_q;
    if (accept) begin
      if (!in_byte_i[7]) begin
        idx_d = '0;
      end else if (idx_q != IdxW'(MaxBytes)) begin
        idx_d = idx_q + IdxW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else begin
      idx_q <= idx_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q <= IdxW'(MaxBytes))
    else $error("byte index beyond limit");

  a_idx_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !in_byte_i[7]) |=> (idx_q == '0))
    else $error("byte index not cleared after end of number");
`endif

endmodule

/* src/vzd_fifo.sv */
// short queue between front and back
module vzd_fifo #(
  parameter int unsigned DataWidth = 12,
  parameter int unsigned Depth     = vzd_pkg::QueueDepth
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  logic [DataWidth-1:0] push_data_i,
  output logic                 full_o,
  input  logic                 pop_i,
  output logic                 pop_valid_o,
  output logic [DataWidth-1:0] pop_data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [DataWidth-1:0] mem_q [Depth];
  logic [PtrW-1:0]      wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]      count_q, count_d;
  logic                 do_push, do_pop;

  assign full_o      = (count_q == CntW'(Depth));
  assign pop_valid_o = (count_q != '0);
  assign pop_data_o  = mem_q[rd_ptr_q];
  assign do_push     = push_i & ~full_o;
  assign do_pop      = pop_i & pop_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    count_d = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("queue fill count beyond depth");
`endif

endmodule

/* src/vzd_back.sv */
// back end: accumulates payload, applies zigzag mapping in signed mode, holds the result register
module vzd_back #(
  parameter int unsigned ValueWidth = vzd_pkg::DefaultValueWidth
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      signed_mode_i,
  input  logic                                      pop_valid_i,
  output logic                                      pop_o,
  input  logic [$clog2((ValueWidth + 6) / 7)-1:0]   pos_i,
  input  logic [vzd_pkg::PayloadBits-1:0]           payload_i,
  input  vzd_pkg::vzd_tag_t                         tag_i,
  output logic                                      out_valid_o,
  input  logic                                      out_ready_i,
  output logic [ValueWidth-1:0]                     value_bits_o,
  output logic                                      overlong_o
);

  localparam int unsigned MaxBytes = (ValueWidth + 6) / 7;
  localparam int unsigned ShW      = $clog2(vzd_pkg::PayloadBits * MaxBytes);

  logic [ValueWidth-1:0] acc_q, acc_d, acc_next, placed, half, mapped;
  logic                  ovf_q, ovf_d;
  logic                  out_valid_q, out_valid_d;
  logic [ValueWidth-1:0] value_q;
  logic                  overlong_q;
  logic [ShW-1:0]        shamt;
  logic                  can_load, emit;

  assign shamt    = ShW'(pos_i) * ShW'(vzd_pkg::PayloadBits);
  assign placed   = ValueWidth'(payload_i) << shamt;
  assign acc_next = tag_i.excess ? acc_q : (acc_q | placed);

  // zigzag back: odd gives the inverted half, even the half
  assign half   = acc_next >> 1;
  assign mapped = signed_mode_i ? (acc_next[0] ? ~half : half) : acc_next;

  assign can_load = ~out_valid_q | out_ready_i;
  assign pop_o    = pop_valid_i & (~tag_i.last | can_load);
  assign emit     = pop_o & tag_i.last;

  always_comb begin
    acc_d = acc_q;
    ovf_d = ovf_q;
    if (pop_o) begin
      if (tag_i.last) begin
        acc_d = '0;
        ovf_d = 1'b0;
      end else begin
        acc_d = acc_next;
        ovf_d = ovf_q | tag_i.excess;
      end
    end
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      acc_q       <= acc_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      value_q    <= mapped;
      overlong_q <= ovf_q | tag_i.excess;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign value_bits_o = value_q;
  assign overlong_o   = overlong_q;

`ifndef NO_ASSERTIONS
  a_emit_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |=> (out_valid_q && acc_q == '0 && !ovf_q))
    else $error("result not loaded or accumulator not cleared");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |-> !emit)
    else $error("pending result overwritten");
`endif

endmodule

/* src/varint_zigzag_decoder.sv */
// top level of the base-128 varint decoder with zigzag signed mapping
//
// usage
// - input channel in_valid_i/in_ready_o/in_byte_i carries one stream byte per item;
//   bit 7 set means more bytes of the same number follow
// - output channel out_valid_o/out_ready_i carries one decoded number per item:
//   value_bits_o and overlong_o
// - cfg_we_i/cfg_wdata_i write signed_mode; change it only while the block is idle
// - throughput: one byte per cycle while the queue is not full, set by the single shift-or into the accumulator
// - out_valid_o rises once the final byte has passed the queue and the back end has
//   loaded the result register; that load waits while an earlier result is still held
// - bytes past the position limit are dropped and flag the number as overlong
// - a stalled receiver holds the result register; the back end keeps folding in
//   continuation bytes, and the front end keeps taking bytes until the two-entry
//   queue fills, then drops in_ready_o
// - reset clears signed_mode, the byte position, accumulator, queue and result valid
module varint_zigzag_decoder #(
  parameter int unsigned ValueWidth = vzd_pkg::DefaultValueWidth
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic                  cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [7:0]            in_byte_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [ValueWidth-1:0] value_bits_o,
  output logic                  overlong_o
);

  // number of bytes that can carry payload for this value width
  localparam int unsigned MaxBytes = (ValueWidth + 6) / 7;
  localparam int unsigned PosW     = $clog2(MaxBytes);
  localparam int unsigned TagW     = $bits(vzd_pkg::vzd_tag_t);
  localparam int unsigned QueueW   = TagW + PosW + vzd_pkg::PayloadBits;

  // signed mode register
  logic signed_mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      signed_mode_q <= 1'b0;
    end else if (cfg_we_i) begin
      signed_mode_q <= cfg_wdata_i;
    end
  end

  // front end outputs
  logic                            push, full;
  logic [PosW-1:0]                 push_pos;
  logic [vzd_pkg::PayloadBits-1:0] push_payload;
  vzd_pkg::vzd_tag_t               push_tag;

  // queue outputs
  logic                            pop, pop_valid;
  logic [QueueW-1:0]               pop_data;
  logic [PosW-1:0]                 pop_pos;
  logic [vzd_pkg::PayloadBits-1:0] pop_payload;
  vzd_pkg::vzd_tag_t               pop_tag;

  vzd_front #(
    .MaxBytes (MaxBytes)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_byte_i  (in_byte_i),
    .full_i     (full),
    .push_o     (push),
    .pos_o      (push_pos),
    .payload_o  (push_payload),
    .tag_o      (push_tag)
  );

  // queue entry layout: tag, position, payload
  vzd_fifo #(
    .DataWidth (QueueW),
    .Depth     (vzd_pkg::QueueDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i ({push_tag, push_pos, push_payload}),
    .full_o      (full),
    .pop_i       (pop),
    .pop_valid_o (pop_valid),
    .pop_data_o  (pop_data)
  );

  assign pop_payload = pop_data[vzd_pkg::PayloadBits-1:0];
  assign pop_pos     = pop_data[vzd_pkg::PayloadBits +: PosW];
  assign pop_tag     = vzd_pkg::vzd_tag_t'(pop_data[vzd_pkg::PayloadBits + PosW +: TagW]);

  vzd_back #(
    .ValueWidth (ValueWidth)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .signed_mode_i (signed_mode_q),
    .pop_valid_i   (pop_valid),
    .pop_o         (pop),
    .pos_i         (pop_pos),
    .payload_i     (pop_payload),
    .tag_i         (pop_tag),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .value_bits_o  (value_bits_o),
    .overlong_o    (overlong_o)
  );

endmodule

/* bench/testbench.sv */
// self-checking bench for the varint zigzag decoder: byte stream in, decoded numbers out
module testbench;

  localparam int unsigned ValueW     = vzd_pkg::DefaultValueWidth;
  localparam int unsigned MaxBytes   = (ValueW + 6) / 7;
  localparam int unsigned PhaseBytes = 210;
  localparam int unsigned HoldCycles = 90;
  localparam int unsigned LimitTime  = 5_000_000;

  // plain mode: zero, largest single byte, full 32-bit value, overlong ending in excess byte
  localparam logic [7:0] PlainCases [14] = '{
    8'h00, 8'h7f,
    8'hff, 8'hff, 8'hff, 8'hff, 8'h0f,
    8'h81, 8'h82, 8'h83, 8'h84, 8'h85, 8'h86, 8'h07
  };
  // zigzag mode: minus one, plus one, largest positive, most negative with dropped top bits
  localparam logic [7:0] ZigzagCases [12] = '{
    8'h01, 8'h02,
    8'hfe, 8'hff, 8'hff, 8'hff, 8'h0f,
    8'hff, 8'hff, 8'hff, 8'hff, 8'h7f
  };
  localparam int unsigned TxIdle [4] = '{25, 0, 0, 50};
  localparam int unsigned RxIdle [4] = '{25, 0, 40, 50};

  typedef struct packed {
    logic [ValueW-1:0] value;
    logic              overlong;
  } number_t;

  class decoded_number_board;
    bit                signed_mode;
    logic [ValueW-1:0] acc;
    int unsigned       nbytes;
    bit                excess_seen;
    number_t           expected_q[$];
    int unsigned       errors;

    function new();
      signed_mode = 1'b0;
      acc         = '0;
      nbytes      = 0;
      excess_seen = 1'b0;
      errors      = 0;
    endfunction

    function void set_mode(bit m);
      signed_mode = m;
    endfunction

    function bit mid_number();
      return (nbytes != 0) || excess_seen;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    // fold one accepted byte in, queue a number when the byte ends it
    function void take_byte(logic [7:0] b);
      logic [63:0] shifted;
      number_t     num;
      if (nbytes < MaxBytes) begin
        shifted = 64'(b[6:0]) << (7 * nbytes);
        acc     = acc | shifted[ValueW-1:0];
        nbytes++;
      end else begin
        excess_seen = 1'b1;
      end
      if (b[7]) return;
      if (signed_mode) begin
        num.value = acc[0] ? ~(acc >> 1) : (acc >> 1);
      end else begin
        num.value = acc;
      end
      num.overlong = excess_seen;
      expected_q.push_back(num);
      acc         = '0;
      nbytes      = 0;
      excess_seen = 1'b0;
    endfunction

    function void match_number(logic [ValueW-1:0] value, logic overlong);
      number_t exp_num;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected number, value %h overlong %b", $time, value, overlong);
        errors++;
        return;
      end
      exp_num = expected_q.pop_front();
      if (value !== exp_num.value) begin
        $display("%0t: value mismatch, expected %h actual %h", $time, exp_num.value, value);
        errors++;
      end
      if (overlong !== exp_num.overlong) begin
        $display("%0t: overlong mismatch, expected %b actual %b",
                 $time, exp_num.overlong, overlong);
        errors++;
      end
    endfunction
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              cfg_we_i;
  logic              cfg_wdata_i;
  logic              in_valid_i;
  logic              in_ready_o;
  logic [7:0]        in_byte_i;
  logic              out_valid_o;
  logic              out_ready_i;
  logic [ValueW-1:0] value_bits_o;
  logic              overlong_o;

  int unsigned tx_idle_pct;
  int unsigned rx_idle_pct;
  bit          hold_req;

  decoded_number_board board = new();

  always #5 clk_i = ~clk_i;

  varint_zigzag_decoder #(
    .ValueWidth(ValueW)
  ) i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_byte_i   (in_byte_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .value_bits_o(value_bits_o),
    .overlong_o  (overlong_o)
  );

  // mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap(int unsigned pct);
    int unsigned r;
    if ($urandom_range(0, 99) >= pct) return 0;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  task automatic send_byte(logic [7:0] b);
    int unsigned gap;
    gap = pick_gap(tx_idle_pct);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_byte_i  <= b;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    board.take_byte(b);
  endtask

  // mostly well-formed numbers, some overlong ones, a little raw noise
  task automatic send_random_number(inout int unsigned count);
    int unsigned len;
    int unsigned r;
    logic [7:0]  b;
    r = $urandom_range(0, 99);
    if (r < 8) begin
      send_byte(8'($urandom_range(0, 255)));
      count++;
      return;
    end
    if (r < 40) len = 1;
    else if (r < 60) len = $urandom_range(2, 4);
    else if (r < 88) len = MaxBytes;
    else len = $urandom_range(MaxBytes + 1, MaxBytes + 3);
    for (int i = 0; i < len; i++) begin
      b = 8'($urandom_range(0, 255));
      if ($urandom_range(0, 9) == 0) b[6:0] = $urandom_range(0, 1) ? 7'h7f : 7'h00;
      b[7] = (i != len - 1);
      send_byte(b);
      count++;
    end
  endtask

  // only once every number is out and the pipeline has drained
  task automatic write_mode(bit m);
    while (board.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= m;
    @(posedge clk_i);
    board.set_mode(m);
    cfg_we_i <= 1'b0;
  endtask

  initial begin : stimulus
    int unsigned sent;
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = 1'b0;
    in_valid_i  = 1'b0;
    in_byte_i   = 8'h00;
    hold_req    = 1'b0;
    tx_idle_pct = 20;
    rx_idle_pct = 20;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    write_mode(1'b0);
    foreach (PlainCases[i]) send_byte(PlainCases[i]);
    in_valid_i <= 1'b0;
    write_mode(1'b1);
    foreach (ZigzagCases[i]) send_byte(ZigzagCases[i]);
    in_valid_i <= 1'b0;

    for (int ph = 0; ph < 4; ph++) begin
      write_mode(ph % 2 == 0);
      tx_idle_pct = TxIdle[ph];
      rx_idle_pct = RxIdle[ph];
      // receiver holds off while bytes keep coming, so the input has to stall
      if (ph == 2) hold_req = 1'b1;
      sent = 0;
      while (sent < PhaseBytes) send_random_number(sent);
      if (board.mid_number()) send_byte(8'($urandom_range(0, 127)));
      in_valid_i <= 1'b0;
    end

    while (board.pending() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (board.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin : result_sink
    int unsigned stall_left;
    stall_left  = 0;
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o === 1'b1 && out_ready_i) board.match_number(value_bits_o, overlong_o);
      if (hold_req) begin
        hold_req   = 1'b0;
        stall_left = HoldCycles;
      end else if (stall_left == 0) begin
        stall_left = pick_gap(rx_idle_pct);
      end
      if (stall_left > 0) begin
        out_ready_i <= 1'b0;
        stall_left--;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    #(LimitTime);
    $display("CHECK FAILED");
    $finish;
  end

endmodule
